// File: rtl/bfpd_pkg.sv
`default_nettype none

package bfpd_pkg;

  localparam int unsigned DEF_MAX_SRC_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 4096;
  localparam int unsigned DEF_MAX_DST_WIDTH  = 512;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CLAMP_W    = 14;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned OX_W       = 9;
  localparam int unsigned OY_W       = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_UP  = 3'd4;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
    logic [CNT_W-1:0] count;
  } bin_t;

endpackage

`default_nettype wire

// File: rtl/box_filter_pixel_downscale_top.sv
// Box-filter downscaler for a raster stream of BGR source pixels.
// The in channel takes one source pixel per transfer; first_of_frame marks
// the first pixel of a frame. The out channel gives one averaged pixel with
// its output column and row whenever the last source pixel of a bin arrives;
// frame_done flags the final output pixel of a frame.
// The cfg channel writes the five size and orientation registers; it is
// always ready and should only be used while the block is idle.
// A pixel that closes no bin reads its column entry in the accumulator memory
// and then writes it back.
// A pixel that closes a bin also runs the bit-serial division of the 32-bit
// sums by the pixel count and then loads the output register.
// The output register lets the next pixel enter while a result waits for
// the receiver. When the receiver stalls and a second result is ready,
// the block holds that result and accepts no further pixel.
// After reset and after every write to one of the five registers, a clearing
// pass zeroes the accumulators while the bin step sizes are divided out; the
// same pass runs when a first pixel mark arrives in the middle of a frame.
`default_nettype none

module box_filter_pixel_downscale_top #(
  parameter int unsigned MAX_SRC_WIDTH  = bfpd_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bfpd_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_DST_WIDTH  = bfpd_pkg::DEF_MAX_DST_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bfpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bfpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            first_of_frame_i,
  input  wire logic [bfpd_pkg::CH_W-1:0]       in_blue_i,
  input  wire logic [bfpd_pkg::CH_W-1:0]       in_green_i,
  input  wire logic [bfpd_pkg::CH_W-1:0]       in_red_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [bfpd_pkg::OX_W-1:0]            out_x_o,
  output logic [bfpd_pkg::OY_W-1:0]            out_y_o,
  output logic [bfpd_pkg::CH_W-1:0]            out_blue_o,
  output logic [bfpd_pkg::CH_W-1:0]            out_green_o,
  output logic [bfpd_pkg::CH_W-1:0]            out_red_o,
  output logic                                 frame_done_o
);

  import bfpd_pkg::*;

  localparam int unsigned MAXS = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                 MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int unsigned DW   = $clog2(MAXS + 1);
  localparam int unsigned XW   = $clog2(MAX_DST_WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  // Configuration registers and their effective values.
  logic [CFG_DATA_W-1:0] src_width_q, src_height_q, dst_height_q;
  logic [9:0]            dst_width_q;
  logic                  bottom_up_q;
  logic                  cfg_go_q;
  logic                  cfg_fire;
  logic                  cfg_hit;

  logic [CLAMP_W-1:0] sw_c, sh_c, dw_c, dh_c, dw_hi;
  logic [DW-1:0]      sw_e, sh_e, dw_e, dh_e;

  always_comb begin
    sw_c = CLAMP_W'(src_width_q);
    if (sw_c == '0) begin
      sw_c = CLAMP_W'(1);
    end else if (sw_c > CLAMP_W'(MAX_SRC_WIDTH)) begin
      sw_c = CLAMP_W'(MAX_SRC_WIDTH);
    end
    sh_c = CLAMP_W'(src_height_q);
    if (sh_c == '0) begin
      sh_c = CLAMP_W'(1);
    end else if (sh_c > CLAMP_W'(MAX_SRC_HEIGHT)) begin
      sh_c = CLAMP_W'(MAX_SRC_HEIGHT);
    end
    dw_hi = (sw_c < CLAMP_W'(MAX_DST_WIDTH)) ? sw_c : CLAMP_W'(MAX_DST_WIDTH);
    dw_c  = CLAMP_W'(dst_width_q);
    if (dw_c == '0) begin
      dw_c = CLAMP_W'(1);
    end else if (dw_c > dw_hi) begin
      dw_c = dw_hi;
    end
    dh_c = CLAMP_W'(dst_height_q);
    if (dh_c == '0) begin
      dh_c = CLAMP_W'(1);
    end else if (dh_c > sh_c) begin
      dh_c = sh_c;
    end
    sw_e = DW'(sw_c);
    sh_e = DW'(sh_c);
    dw_e = DW'(dw_c);
    dh_e = DW'(dh_c);
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_fire && (cfg_index_i == CFG_SRC_WIDTH ||
                       cfg_index_i == CFG_SRC_HEIGHT || cfg_index_i == CFG_DST_WIDTH ||
                       cfg_index_i == CFG_DST_HEIGHT || cfg_index_i == CFG_BOTTOM_UP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= CFG_DATA_W'(1);
      src_height_q <= CFG_DATA_W'(1);
      dst_width_q  <= 10'd1;
      dst_height_q <= CFG_DATA_W'(1);
      bottom_up_q  <= 1'b0;
      cfg_go_q     <= 1'b1;
    end else begin
      cfg_go_q <= cfg_hit;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i;
          CFG_SRC_HEIGHT: src_height_q <= cfg_data_i;
          CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i[9:0];
          CFG_DST_HEIGHT: dst_height_q <= cfg_data_i;
          CFG_BOTTOM_UP:  bottom_up_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Bin step sizes: source units per bin as quotient and remainder.
  logic [DW-1:0] qw, rw, qh, rh;
  logic          busy_w, busy_h, kv;

  bfpd_div #(.NUM_W(DW), .DEN_W(DW)) u_div_w (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cfg_go_q),
    .num_i  (sw_e),
    .den_i  (dw_e),
    .busy_o (busy_w),
    .quot_o (qw),
    .rem_o  (rw)
  );

  bfpd_div #(.NUM_W(DW), .DEN_W(DW)) u_div_h (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cfg_go_q),
    .num_i  (sh_e),
    .den_i  (dh_e),
    .busy_o (busy_h),
    .quot_o (qh),
    .rem_o  (rh)
  );

  assign kv = !cfg_go_q && !busy_w && !busy_h;

  // Position state.
  logic [DW-1:0] scol_q, scol_d, srow_q, srow_d;
  logic [XW-1:0] cbin_q, cbin_d;
  logic [DW-1:0] cq_q, cq_d, cr_q, cr_d;
  logic [DW-1:0] rbin_q, rbin_d, rq_q, rq_d, rr_q, rr_d, redge_q, redge_d;
  logic          dirty_q, dirty_d;

  logic [DW-1:0] rs_rbin, rs_rq, rs_rr, rs_redge;
  logic [DW:0]   csum, rsum, rdif;
  logic [DW-1:0] cr_n, cq_n, rr_n, rq_n;
  logic          col_last, row_last, row_end, frame_end, emit;

  logic [2:0]      state_q, state_d;
  logic [XW:0]     clr_q, clr_d;
  logic            pend_q, pend_d;
  logic            clr_exit;

  always_comb begin
    if (bottom_up_q) begin
      rs_rbin = dh_e - DW'(1);
      rs_rq   = sh_e - qh - DW'(rh != '0);
      rs_rr   = (rh != '0) ? dh_e - rh : '0;
      rs_redge = sh_e - rs_rq;
    end else begin
      rs_rbin  = '0;
      rs_rq    = qh;
      rs_rr    = rh;
      rs_redge = qh;
    end
  end

  always_comb begin
    col_last  = ({1'b0, scol_q} + 1'b1) >= {1'b0, cq_q};
    row_last  = ({1'b0, srow_q} + 1'b1) >= {1'b0, redge_q};
    row_end   = ({1'b0, scol_q} + 1'b1) >= {1'b0, sw_e};
    frame_end = row_end && (({1'b0, srow_q} + 1'b1) >= {1'b0, sh_e});
    emit      = col_last && row_last;

    csum = {1'b0, cr_q} + {1'b0, rw};
    if (csum >= {1'b0, dw_e}) begin
      cr_n = DW'(csum - {1'b0, dw_e});
      cq_n = cq_q + qw + DW'(1);
    end else begin
      cr_n = DW'(csum);
      cq_n = cq_q + qw;
    end

    rsum = {1'b0, rr_q} + {1'b0, rh};
    rdif = {1'b0, rr_q} - {1'b0, rh};
    if (bottom_up_q) begin
      if (rdif[DW]) begin
        rr_n = DW'(rsum - {1'b0, rh} - {1'b0, rh} + {1'b0, dh_e});
        rq_n = rq_q - qh - DW'(1);
      end else begin
        rr_n = DW'(rdif);
        rq_n = rq_q - qh;
      end
    end else if (rsum >= {1'b0, dh_e}) begin
      rr_n = DW'(rsum - {1'b0, dh_e});
      rq_n = rq_q + qh + DW'(1);
    end else begin
      rr_n = DW'(rsum);
      rq_n = rq_q + qh;
    end
  end

  always_comb begin
    scol_d  = scol_q;
    srow_d  = srow_q;
    cbin_d  = cbin_q;
    cq_d    = cq_q;
    cr_d    = cr_q;
    rbin_d  = rbin_q;
    rq_d    = rq_q;
    rr_d    = rr_q;
    redge_d = redge_q;
    dirty_d = dirty_q;
    if (clr_exit || (state_q == S_UPD && frame_end)) begin
      scol_d  = '0;
      srow_d  = '0;
      cbin_d  = '0;
      cq_d    = qw;
      cr_d    = rw;
      rbin_d  = rs_rbin;
      rq_d    = rs_rq;
      rr_d    = rs_rr;
      redge_d = rs_redge;
      dirty_d = 1'b0;
    end else if (state_q == S_UPD) begin
      dirty_d = 1'b1;
      if (row_end) begin
        scol_d = '0;
        cbin_d = '0;
        cq_d   = qw;
        cr_d   = rw;
        srow_d = srow_q + DW'(1);
        if (row_last) begin
          if (bottom_up_q) begin
            if (rbin_q != '0) begin
              rbin_d  = rbin_q - DW'(1);
              rq_d    = rq_n;
              rr_d    = rr_n;
              redge_d = sh_e - rq_n;
            end
          end else if (({1'b0, rbin_q} + 1'b1) < {1'b0, dh_e}) begin
            rbin_d  = rbin_q + DW'(1);
            rq_d    = rq_n;
            rr_d    = rr_n;
            redge_d = rq_n;
          end
        end
      end else begin
        scol_d = scol_q + DW'(1);
        if (col_last && ((DW + 1)'(cbin_q) + 1'b1) < {1'b0, dw_e}) begin
          cbin_d = cbin_q + XW'(1);
          cq_d   = cq_n;
          cr_d   = cr_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q  <= '0;
      srow_q  <= '0;
      cbin_q  <= '0;
      cq_q    <= '0;
      cr_q    <= '0;
      rbin_q  <= '0;
      rq_q    <= '0;
      rr_q    <= '0;
      redge_q <= '0;
      dirty_q <= 1'b0;
    end else begin
      scol_q  <= scol_d;
      srow_q  <= srow_d;
      cbin_q  <= cbin_d;
      cq_q    <= cq_d;
      cr_q    <= cr_d;
      rbin_q  <= rbin_d;
      rq_q    <= rq_d;
      rr_q    <= rr_d;
      redge_q <= redge_d;
      dirty_q <= dirty_d;
    end
  end

  // Accumulator memory, one entry per output column.
  bin_t          mem [MAX_DST_WIDTH];
  bin_t          rdata_q;
  bin_t          wdata;
  bin_t          upd;
  logic          we, rd_en;
  logic [XW-1:0] waddr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[cbin_q];
    end
  end

  logic [CH_W-1:0] px_b_q, px_g_q, px_r_q;
  logic            in_fire;

  assign in_ready_o = (state_q == S_IDLE) && kv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    upd.blue  = rdata_q.blue + SUM_W'(px_b_q);
    upd.green = rdata_q.green + SUM_W'(px_g_q);
    upd.red   = rdata_q.red + SUM_W'(px_r_q);
    upd.count = rdata_q.count + CNT_W'(1);
  end

  // Averaging dividers.
  logic             avg_go;
  logic [CNT_W-1:0] avg_den;
  logic [SUM_W-1:0] qb, qg, qr;
  logic             busy_b, busy_g, busy_r;

  assign avg_den = (upd.count == '0) ? CNT_W'(1) : upd.count;

  bfpd_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (avg_go), .num_i (upd.blue),
    .den_i (avg_den), .busy_o (busy_b), .quot_o (qb), .rem_o ()
  );

  bfpd_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (avg_go), .num_i (upd.green),
    .den_i (avg_den), .busy_o (busy_g), .quot_o (qg), .rem_o ()
  );

  bfpd_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (avg_go), .num_i (upd.red),
    .den_i (avg_den), .busy_o (busy_r), .quot_o (qr), .rem_o ()
  );

  // Control sequencer.
  logic out_load;

  assign clr_exit = (state_q == S_CLR) && (clr_q == (XW + 1)'(MAX_DST_WIDTH)) && kv;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pend_d   = pend_q;
    we       = 1'b0;
    waddr    = cbin_q;
    wdata    = upd;
    rd_en    = 1'b0;
    avg_go   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (first_of_frame_i && dirty_q) begin
            state_d = S_CLR;
            clr_d   = '0;
            pend_d  = 1'b1;
          end else begin
            rd_en   = 1'b1;
            state_d = S_UPD;
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        we = 1'b1;
        if (emit) begin
          wdata   = '0;
          avg_go  = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (!busy_b && !busy_g && !busy_r) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_CLR: begin
        if (clr_q != (XW + 1)'(MAX_DST_WIDTH)) begin
          we    = 1'b1;
          waddr = clr_q[XW-1:0];
          wdata = '0;
          clr_d = clr_q + (XW + 1)'(1);
        end else if (kv) begin
          state_d = pend_q ? S_RD : S_IDLE;
          pend_d  = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_hit) begin
      state_d = S_CLR;
      clr_d   = '0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  // Pixel and result metadata.
  logic [OX_W-1:0] mx_q;
  logic [OY_W-1:0] my_q;
  logic            mfd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_b_q <= in_blue_i;
      px_g_q <= in_green_i;
      px_r_q <= in_red_i;
    end
    if (avg_go) begin
      mx_q  <= OX_W'(cbin_q);
      my_q  <= OY_W'(rbin_q);
      mfd_q <= frame_end && ((DW + 1)'(cbin_q) + 1'b1 == {1'b0, dw_e});
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_o      <= mx_q;
      out_y_o      <= my_q;
      out_blue_o   <= qb[CH_W-1:0];
      out_green_o  <= qg[CH_W-1:0];
      out_red_o    <= qr[CH_W-1:0];
      frame_done_o <= mfd_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !cfg_hit |=> state_q == S_UPD || state_q == S_CLR)
    else $error("accepted pixel did not start an update or clearing pass");

  a_ready_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> kv && !pend_q)
    else $error("pixel accepted before step sizes were ready");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_go && !cfg_hit |=> busy_b && state_q == S_DIV)
    else $error("averaging divider did not start on bin close");

  a_clr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> clr_q <= (XW + 1)'(MAX_DST_WIDTH))
    else $error("clearing pass ran past the memory");
`endif

endmodule

`default_nettype wire

// File: rtl/bfpd_div.sv
`default_nettype none

module bfpd_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 25
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quot_o,
  output logic [DEN_W-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: test/box_filter_pixel_downscale_top_test.sv
`timescale 1ns / 1ps

module box_filter_pixel_downscale_top_test;
  import bfpd_pkg::*;

  localparam int unsigned BINS = DEF_MAX_DST_WIDTH;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam int unsigned SETTLE_CYCLES = DEF_MAX_DST_WIDTH + 100;

  typedef struct {
    bit             sof;
    bit [CH_W-1:0]  blue;
    bit [CH_W-1:0]  green;
    bit [CH_W-1:0]  red;
  } pixel_t;

  typedef struct {
    bit [OX_W-1:0] x;
    bit [OY_W-1:0] y;
    bit [CH_W-1:0] blue;
    bit [CH_W-1:0] green;
    bit [CH_W-1:0] red;
    bit            done;
  } avg_pixel_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  first_of_frame_i;
  logic [CH_W-1:0]       in_blue_i;
  logic [CH_W-1:0]       in_green_i;
  logic [CH_W-1:0]       in_red_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [OX_W-1:0]       out_x_o;
  logic [OY_W-1:0]       out_y_o;
  logic [CH_W-1:0]       out_blue_o;
  logic [CH_W-1:0]       out_green_o;
  logic [CH_W-1:0]       out_red_o;
  logic                  frame_done_o;

  box_filter_pixel_downscale_top i_dut (.*);

  pixel_t     pixel_q[$];
  avg_pixel_t avg_q[$];
  int unsigned error_count = 0;
  bit          hold_pixels = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;

  int unsigned reg_sw, reg_sh, reg_dw, reg_dh, reg_bu;
  int unsigned acc_blue[BINS];
  int unsigned acc_green[BINS];
  int unsigned acc_red[BINS];
  int unsigned acc_count[BINS];
  int unsigned pos_col, pos_row, col_bin, row_bin, col_edge, row_edge;

  function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_sw();
    return clampv(reg_sw, 1, DEF_MAX_SRC_WIDTH);
  endfunction

  function automatic int unsigned eff_sh();
    return clampv(reg_sh, 1, DEF_MAX_SRC_HEIGHT);
  endfunction

  function automatic int unsigned eff_dw();
    int unsigned hi;
    hi = eff_sw() < DEF_MAX_DST_WIDTH ? eff_sw() : DEF_MAX_DST_WIDTH;
    return clampv(reg_dw, 1, hi);
  endfunction

  function automatic int unsigned eff_dh();
    return clampv(reg_dh, 1, eff_sh());
  endfunction

  function automatic int unsigned bin_lo(int unsigned i, int unsigned s, int unsigned d);
    longint unsigned p;
    p = longint'(i) * longint'(s);
    return int'(p / d);
  endfunction

  function automatic int unsigned bin_hi(int unsigned i, int unsigned s, int unsigned d);
    int unsigned a, b;
    a = bin_lo(i, s, d) + 1;
    b = bin_lo(i + 1, s, d);
    return b > a ? b : a;
  endfunction

  function automatic int unsigned row_limit(int unsigned rb);
    if (reg_bu != 0) return eff_sh() - bin_lo(rb, eff_sh(), eff_dh());
    return bin_hi(rb, eff_sh(), eff_dh());
  endfunction

  task automatic restart_frame();
    for (int i = 0; i < BINS; i++) begin
      acc_blue[i] = 0;
      acc_green[i] = 0;
      acc_red[i] = 0;
      acc_count[i] = 0;
    end
    pos_col = 0;
    pos_row = 0;
    col_bin = 0;
    col_edge = bin_hi(0, eff_sw(), eff_dw());
    row_bin = reg_bu != 0 ? eff_dh() - 1 : 0;
    row_edge = row_limit(row_bin);
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SRC_WIDTH: reg_sw = val;
      CFG_SRC_HEIGHT: reg_sh = val;
      CFG_DST_WIDTH: reg_dw = val[9:0];
      CFG_DST_HEIGHT: reg_dh = val;
      CFG_BOTTOM_UP: reg_bu = val[0];
      default: return;
    endcase
    restart_frame();
  endtask

  task automatic predict_average(pixel_t p);
    int unsigned sw, sh, dw, x, n;
    bit col_last, row_last, row_end, frame_end;
    avg_pixel_t e;
    sw = eff_sw();
    sh = eff_sh();
    dw = eff_dw();
    if (p.sof) restart_frame();
    x = col_bin < BINS ? col_bin : BINS - 1;
    acc_blue[x] += p.blue;
    acc_green[x] += p.green;
    acc_red[x] += p.red;
    acc_count[x] = (acc_count[x] + 1) & 32'h1FF_FFFF;
    col_last = pos_col + 1 >= col_edge;
    row_last = pos_row + 1 >= row_edge;
    row_end = pos_col + 1 >= sw;
    frame_end = row_end && (pos_row + 1 >= sh);
    if (col_last && row_last) begin
      n = acc_count[x] != 0 ? acc_count[x] : 1;
      e.x = x;
      e.y = row_bin;
      e.blue = acc_blue[x] / n;
      e.green = acc_green[x] / n;
      e.red = acc_red[x] / n;
      e.done = frame_end && (x == dw - 1);
      avg_q.push_back(e);
      acc_blue[x] = 0;
      acc_green[x] = 0;
      acc_red[x] = 0;
      acc_count[x] = 0;
    end
    if (frame_end) begin
      restart_frame();
    end else if (row_end) begin
      pos_col = 0;
      col_bin = 0;
      col_edge = bin_hi(0, sw, dw);
      if (row_last) begin
        if (reg_bu != 0) begin
          if (row_bin > 0) row_bin--;
        end else if (row_bin + 1 < eff_dh()) begin
          row_bin++;
        end
        row_edge = row_limit(row_bin);
      end
      pos_row++;
    end else begin
      pos_col++;
      if (col_last && col_bin + 1 < dw) begin
        col_bin++;
        col_edge = bin_hi(col_bin, sw, dw);
      end
    end
  endtask

  task automatic report(string field, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      first_of_frame_i <= 1'b0;
      in_blue_i <= '0;
      in_green_i <= '0;
      in_red_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        p.sof = first_of_frame_i;
        p.blue = in_blue_i;
        p.green = in_green_i;
        p.red = in_red_i;
        predict_average(p);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() > 0 && !hold_pixels) begin
          p = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          first_of_frame_i <= p.sof;
          in_blue_i <= p.blue;
          in_green_i <= p.green;
          in_red_i <= p.red;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    avg_pixel_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (avg_q.size() == 0) begin
          report("unexpected output transfers", 1, 0);
        end else begin
          e = avg_q.pop_front();
          if (out_x_o !== e.x) report("out_x", out_x_o, e.x);
          if (out_y_o !== e.y) report("out_y", out_y_o, e.y);
          if (out_blue_o !== e.blue) report("out_blue", out_blue_o, e.blue);
          if (out_green_o !== e.green) report("out_green", out_green_o, e.green);
          if (out_red_o !== e.red) report("out_red", out_red_o, e.red);
          if (frame_done_o !== e.done) report("frame_done", frame_done_o, e.done);
        end
      end
      stall_cycle++;
      if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ((stall_cycle % 16) < 10);
      endcase
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh, int unsigned bu);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_BOTTOM_UP, bu);
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid_i || avg_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic bit [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_pixel(bit sof, int unsigned b, int unsigned g, int unsigned r);
    pixel_t p;
    p.sof = sof;
    p.blue = b;
    p.green = g;
    p.red = r;
    pixel_q.push_back(p);
  endtask

  task automatic add_random_pixels(int unsigned n, bit mark_first);
    for (int unsigned i = 0; i < n; i++) begin
      add_pixel((i == 0 && mark_first) || ($urandom_range(0, 99) < 3),
                rand_channel(), rand_channel(), rand_channel());
    end
  endtask

  initial begin
    int unsigned sent, frames, pixels, phase;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    reg_sw = 1;
    reg_sh = 1;
    reg_dw = 1;
    reg_dh = 1;
    reg_bu = 0;
    restart_frame();
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset sizes every pixel is a bin of its own.
    add_pixel(1, 0, 0, 0);
    add_pixel(0, 255, 255, 255);
    add_pixel(1, 255, 0, 128);
    add_pixel(0, 1, 2, 3);
    wait_idle();

    write_reg(CFG_UNUSED_LO, 13'h1FFF);
    write_reg(CFG_UNUSED_HI, 0);
    set_sizes(0, 0, 0, 0, 0);
    add_random_pixels(3, 1);
    wait_idle();

    // Oversize output width clamps to the maximum of 512 columns; one bin is two columns wide.
    set_sizes(513, 1, 1023, 8191, 1);
    add_random_pixels(513, 1);
    wait_idle();

    // Oversize source clamps to the maximum; bottom-up starts at the last output row.
    set_sizes(8191, 8191, 1023, 8191, 1);
    add_random_pixels(20, 1);
    wait_idle();

    sent = 540;
    phase = 0;
    while (sent < 1850) begin
      set_sizes($urandom_range(0, 12), $urandom_range(0, 10), $urandom_range(0, 14),
                $urandom_range(0, 12), $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) write_reg($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI),
                                               $urandom);
      frames = $urandom_range(1, 4);
      for (int unsigned f = 0; f < frames; f++) begin
        pixels = eff_sw() * eff_sh();
        if ($urandom_range(0, 9) == 0) pixels = $urandom_range(1, pixels);
        add_random_pixels(pixels, $urandom_range(0, 99) < 85);
        sent += pixels;
      end
      phase++;
      if (phase % 7 == 3) begin
        while (pixel_q.size() > pixels / 2) @(posedge clk_i);
        hold_pixels = 1'b1;
        while (in_valid_i || avg_q.size() > 0) @(posedge clk_i);
        repeat ($urandom_range(1, 50)) @(posedge clk_i);
        hold_pixels = 1'b0;
      end
      wait_idle();
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: box_filter_pixel_downscale_top.f
rtl/bfpd_pkg.sv
rtl/bfpd_div.sv
rtl/box_filter_pixel_downscale_top.sv
test/box_filter_pixel_downscale_top_test.sv
